@@ hw/rtl/acpu_pkg.sv @@
`default_nettype none
package acpu_pkg;
	localparam logic [7:0] OP_LDM = 8'd0;
	localparam logic [7:0] OP_LDI = 8'd1;
	localparam logic [7:0] OP_ST = 8'd2;
	localparam logic [7:0] OP_ADD = 8'd3;
	localparam logic [7:0] OP_SUB = 8'd4;
	localparam logic [7:0] OP_MUL = 8'd5;
	localparam logic [7:0] OP_DIV = 8'd6;
	localparam logic [7:0] OP_INC = 8'd7;
	localparam logic [7:0] OP_DEC = 8'd8;
	localparam logic [7:0] OP_AND = 8'd9;
	localparam logic [7:0] OP_OR = 8'd10;
	localparam logic [7:0] OP_NOT = 8'd11;
	localparam logic [7:0] OP_JMP = 8'd12;
	localparam logic [7:0] OP_JZ = 8'd13;
	localparam logic [7:0] OP_JNZ = 8'd14;
	localparam logic [7:0] OP_JG = 8'd15;
	localparam logic [7:0] OP_JL = 8'd16;
	localparam logic [7:0] OP_JGE = 8'd17;
	localparam logic [7:0] OP_JLE = 8'd18;
	localparam logic [7:0] OP_HALT = 8'd19;

	localparam logic [1:0] ST_OVF = 2'd0;
	localparam logic [1:0] ST_CARRY = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_OTHER = 2'd3;

	// Data memory depth; the byte operand addresses every word directly.
	localparam int DATA_DEPTH = 256;

	// Request to the serial arithmetic unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} serial_req_t;

	// Signed 8-bit overflow test on the low bytes.
	function automatic logic ovf8(input logic signed [17:0] v);
		ovf8 = (v < -18'sd128) || (v > 18'sd127);
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/acpu_serial_alu.sv @@
`default_nettype none
// Bit-serial shift-add multiplier and restoring divider; the divider works on the dividend's magnitude.
module acpu_serial_alu #(
	parameter int W = 16
) (
	input wire clk,
	input wire arst_n,
	input acpu_pkg::serial_req_t req,
	input wire [W-1:0] a_in,
	input wire [7:0] b_in,
	output logic busy,
	output logic done,
	output logic [W-1:0] result
);
	import acpu_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0] a_q, r_q;
	logic [W:0] rem_q;
	logic [7:0] b_q;
	logic [CW-1:0] cnt_q;
	logic div_q, busy_q, done_q, neg_q;
	logic [W-1:0] mag;
	logic [W:0] trial;
	logic [W-1:0] res_mag;

	assign mag = a_in[W-1] ? (~a_in + 1'b1) : a_in;
	assign trial = {rem_q[W-1:0], a_q[W-1]} - {{(W-7){1'b0}}, b_q};
	assign res_mag = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= req.is_div & a_in[W-1];
			a_q <= req.is_div ? mag : a_in;
			b_q <= b_in;
			r_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				// One quotient bit a cycle, dividend shifted in from the top.
				a_q <= {a_q[W-2:0], 1'b0};
				if (!trial[W]) begin
					rem_q <= trial;
					r_q <= {r_q[W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-1:0], a_q[W-1]};
					r_q <= {r_q[W-2:0], 1'b0};
				end
			end else begin
				// Multiplier bit from the top, product doubles each step.
				a_q <= {a_q[W-2:0], 1'b0};
				r_q <= {r_q[W-2:0], 1'b0} + (a_q[W-1] ? {{(W-8){1'b0}}, b_q} : '0);
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign result = neg_q ? (~res_mag + 1'b1) : res_mag;
endmodule
`default_nettype wire

@@ hw/rtl/accumulator_cpu_execute_unit.sv @@
`default_nettype none
// Accumulator machine execute unit.
// The slave channel (s_axis_*) takes one instruction word per handshake:
// the opcode in tdata[7:0] and the operand in tdata[15:8]. The master
// channel (m_axis_*) returns one result word per instruction.
// A word is accepted only when the unit is idle and no result waits, so one
// instruction is in flight at a time. Most instructions pass a read state,
// where the data memory word is registered, and an execute state before the
// result is valid. Multiply and divide by a nonzero operand run through a
// bit-serial unit, one bit a cycle over the accumulator width.
// When the receiver stalls, the result stays in the output register and no
// new word is taken until it leaves.
// Reset clears pc, accumulator, status and halt flag, then a clearing pass
// writes zero to every memory word, one a cycle, during which no instruction
// is taken. After a halt, every word returns the same state with halted set
// until the next reset.
module accumulator_cpu_execute_unit #(
	parameter int ACC_WIDTH = 16
) (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	output logic s_axis_tready,
	input wire [15:0] s_axis_tdata, // opcode[7:0], operand[15:8]
	output logic m_axis_tvalid,
	input wire m_axis_tready,
	// next_pc[7:0], accumulator[23:8], status[25:24], halted[26], illegal[27],
	// divide_by_zero[28], zero fill[31:29]
	output logic [31:0] m_axis_tdata
);
	import acpu_pkg::*;

	localparam int W = ACC_WIDTH;
	localparam int AW = $clog2(DATA_DEPTH);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_SER = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;
	localparam logic [2:0] S_EXEC = 3'd5;

	logic [2:0] state_q;
	logic [AW:0] clr_q;
	logic [W-1:0] mem [DATA_DEPTH];
	logic [W-1:0] mrd_q;
	logic [7:0] op_q, opd_q, pc_q;
	logic [W-1:0] acc_q;
	logic [1:0] st_q;
	logic halt_q, ill_q, dz_q;
	logic [31:0] out_q;
	logic [AW-1:0] addr;
	logic s_fire;

	serial_req_t req;
	logic ser_busy, ser_done;
	logic [W-1:0] ser_res;

	assign addr = opd_q[AW-1:0];
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;

	acpu_serial_alu #(.W(W)) u_alu (
		.clk(clk), .arst_n(arst_n), .req(req), .a_in(acc_q), .b_in(opd_q),
		.busy(ser_busy), .done(ser_done), .result(ser_res)
	);

	// The serial unit starts once the memory word has been read.
	always_comb begin
		req.start = (state_q == S_EXEC) && !halt_q &&
			((op_q == OP_MUL) || ((op_q == OP_DIV) && (opd_q != 8'd0)));
		req.is_div = (op_q == OP_DIV);
	end

	function automatic logic [1:0] stat(input logic [W-1:0] r, input logic ovf);
		if (ovf) stat = ST_OVF;
		else if (r[8]) stat = ST_CARRY;
		else if (r == '0) stat = ST_ZERO;
		else stat = ST_OTHER;
	endfunction

	// Execute stage: data memory word is registered in mrd_q.
	logic [W-1:0] n_acc;
	logic [1:0] n_st;
	logic [7:0] n_pc;
	logic n_halt, n_ill, n_dz, n_wr;
	logic signed [17:0] la, lm, lo;
	logic signed [W-1:0] sa;
	logic cond;

	always_comb begin
		la = 18'(signed'(acc_q[7:0]));
		lm = 18'(signed'(mrd_q[7:0]));
		lo = 18'(signed'(opd_q));
		sa = signed'(acc_q);
		n_acc = acc_q; n_st = st_q; n_pc = pc_q + 8'd1;
		n_halt = halt_q; n_ill = 1'b0; n_dz = 1'b0; n_wr = 1'b0; cond = 1'b0;
		case (op_q)
			OP_LDM: begin n_acc = mrd_q; n_st = stat(mrd_q, 1'b0); end
			OP_LDI: begin
				n_acc = {{(W-8){1'b0}}, opd_q}; n_st = stat(n_acc, 1'b0);
			end
			OP_ST: n_wr = 1'b1;
			OP_ADD: begin n_acc = acc_q + mrd_q; n_st = stat(n_acc, ovf8(la + lm)); end
			OP_SUB: begin n_acc = acc_q - mrd_q; n_st = stat(n_acc, ovf8(la - lm)); end
			OP_MUL: begin n_acc = ser_res; n_st = stat(ser_res, ovf8(18'(la * lo))); end
			OP_DIV: begin
				if (opd_q == 8'd0) n_dz = 1'b1;
				else begin
					n_acc = ser_res;
					n_st = stat(ser_res, (la == -18'sd128) && (lo == -18'sd1));
				end
			end
			OP_INC: begin n_acc = acc_q + 1'b1; n_st = stat(n_acc, ovf8(la + 18'sd1)); end
			OP_DEC: begin n_acc = acc_q - 1'b1; n_st = stat(n_acc, ovf8(la - 18'sd1)); end
			OP_AND: n_acc = acc_q & mrd_q;
			OP_OR: n_acc = acc_q | mrd_q;
			OP_NOT: n_acc = (acc_q == '0) ? W'(1) : '0;
			OP_JMP, OP_JZ, OP_JNZ, OP_JG, OP_JL, OP_JGE, OP_JLE: begin
				case (op_q)
					OP_JMP: cond = 1'b1;
					OP_JZ: cond = (sa == 0);
					OP_JNZ: cond = (sa != 0);
					OP_JG: cond = (sa > 0);
					OP_JL: cond = (sa < 0);
					OP_JGE: cond = (sa >= 0);
					default: cond = (sa <= 0);
				endcase
				if (cond) n_pc = {1'b0, opd_q[7:1]};
			end
			OP_HALT: begin n_halt = 1'b1; n_pc = pc_q; end
			default: begin n_ill = 1'b1; n_pc = pc_q; end
		endcase
		if (halt_q) begin
			n_acc = acc_q; n_st = st_q; n_pc = pc_q;
			n_ill = 1'b0; n_dz = 1'b0; n_wr = 1'b0;
		end
	end

	logic exec;
	assign exec = ((state_q == S_EXEC) && !req.start) || ((state_q == S_SER) && ser_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pc_q <= '0; acc_q <= '0; st_q <= ST_OVF; halt_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DATA_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_fire) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: state_q <= req.start ? S_SER : S_OUT;
				S_SER: if (ser_done) state_q <= S_OUT;
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (exec) begin
				pc_q <= n_pc; acc_q <= n_acc; st_q <= n_st; halt_q <= n_halt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q <= s_axis_tdata[7:0];
			opd_q <= s_axis_tdata[15:8];
		end
		if (state_q == S_CLEAR) mem[clr_q[AW-1:0]] <= '0;
		else if (exec && n_wr) mem[addr] <= acc_q;
		mrd_q <= mem[addr];
		if (exec) begin
			ill_q <= n_ill; dz_q <= n_dz;
		end
	end

	always_comb begin
		out_q = '0;
		out_q[7:0] = pc_q;
		out_q[23:8] = 16'(acc_q);
		out_q[25:24] = st_q;
		out_q[26] = halt_q;
		out_q[27] = ill_q;
		out_q[28] = dz_q;
	end

	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> halt_q) else $error("halt flag dropped");
	a_ser_only_in_ser: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done |-> state_q == S_SER) else $error("serial result out of turn");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halt_q) |-> $stable(pc_q)) else $error("pc moved after halt");
	a_ser_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SER |-> ser_busy || ser_done) else $error("serial unit idle");
`endif
endmodule
`default_nettype wire
